>>> hdl/bitmap_page_allocator_top_macros.svh
// Assertion macros for the bitmap page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH

// Checked on every edge outside reset; clk and rst_n come from the using scope.
`define BPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define BPA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hdl/bpa_pkg.sv
// Types, constants and word functions of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

    localparam int BITMAP_WORDS = 4096;
    localparam int WORD_W       = 64;
    localparam int BIT_W        = 6;
    localparam int LEN_W        = BIT_W + 1;
    localparam int WIDX_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int LPAGE_W      = WIDX_W + BIT_W;
    localparam int CNT_W        = LPAGE_W + 1;
    localparam int TOTAL_PAGES  = BITMAP_WORDS * WORD_W;

    // Request and result field widths.
    localparam int REQ_W    = 2;
    localparam int PAGE_W   = 18;
    localparam int COUNT_W  = 19;
    localparam int STATUS_W = 2;
    localparam int XW       = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(BITMAP_WORDS - 1);

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Count of clear bits below the lowest set bit.
    function automatic logic [LEN_W-1:0] tz_count(input logic [WORD_W-1:0] word);
        logic [LEN_W-1:0] res;
        res = LEN_W'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (word[i])
                res = LEN_W'(i);
        end
        return res;
    endfunction

    // Count of clear bits above the highest set bit.
    function automatic logic [LEN_W-1:0] lz_count(input logic [WORD_W-1:0] word);
        logic [LEN_W-1:0] res;
        res = LEN_W'(WORD_W);
        for (int i = 0; i < WORD_W; i++)
        begin
            if (word[i])
                res = LEN_W'(WORD_W - 1 - i);
        end
        return res;
    endfunction

    // Bit e set: pages e-len .. e-1 of the word are all free. Built by doubling.
    function automatic logic [WORD_W:0] run_find(input logic [WORD_W-1:0] free_bits,
                                                 input logic [LEN_W-1:0] len);
        logic [WORD_W:0] q;
        logic [WORD_W:0] res;
        q   = {free_bits, 1'b0};
        res = '1;
        for (int j = 0; j < LEN_W; j++)
        begin
            if (len[j])
                res = (res << (1 << j)) & q;
            q = q & (q << (1 << j));
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] lowest_set(input logic [WORD_W:0] v);
        logic [LEN_W-1:0] res;
        res = '0;
        for (int i = WORD_W; i >= 0; i--)
        begin
            if (v[i])
                res = LEN_W'(i);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/bpa_ifs.sv
// Request and result channel interfaces of the bitmap page allocator.
`default_nettype none

interface bpa_req_if;
    import bpa_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [PAGE_W-1:0]  first_page;
    logic [COUNT_W-1:0] page_count;

    modport source (output valid, output req_type, output first_page,
                    output page_count, input ready);
    modport sink   (input valid, input req_type, input first_page,
                    input page_count, output ready);
endinterface

interface bpa_rsp_if;
    import bpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   base_page;

    modport source (output valid, output status, output base_page, input ready);
    modport sink   (input valid, input status, input base_page, output ready);
endinterface

`default_nettype wire

>>> hdl/bitmap_page_allocator_top.sv
// First-fit bitmap page allocator: one use bit per page in a 4096 x 64 bitmap
// memory with a single read and a single write port, one word a cycle.
// After reset the block clears all BITMAP_WORDS (4096) words of the memory with
// ready low. It then works on one request at a time. Allocate reads the
// bitmap from word 0 up, one word per cycle, until a run fits or the last
// word is read, then sets the run in the words it spans. Free and mark read
// and rewrite the words of their range. The result then goes to the output
// register; a result waiting there does not keep the next request out.
// Throughput is set by the memory read port: one bitmap word per cycle.
`default_nettype none

module bitmap_page_allocator_top (
    input  logic      clk,
    input  logic      rst_n,
    bpa_req_if.sink   req,
    bpa_rsp_if.source rsp
);
    import bpa_pkg::*;

    logic [WORD_W-1:0] mem [BITMAP_WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    state_t state_reg, state_next;

    logic              issue_en;
    logic [WIDX_W-1:0] issue_addr;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic              pv_reg, pv_next;
    logic [WIDX_W-1:0] pa_reg;
    logic [WIDX_W-1:0] ptr_reg, ptr_next;
    logic              ptr_end_reg, ptr_end_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [LPAGE_W-1:0] start_reg, start_next;
    logic [LPAGE_W-1:0] lo_pg_reg, lo_pg_next;
    logic [LPAGE_W-1:0] hi_pg_reg, hi_pg_next;
    logic               set_reg, set_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [LPAGE_W-1:0]  res_base_reg, res_base_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PAGE_W-1:0]   out_base_reg, out_base_next;

    // request checks
    logic [XW-1:0] first_x, count_x, total_x;
    logic          rng_bad, alloc_bad;

    // scan datapath
    logic [LPAGE_W-1:0] wbase, lead_base, in_base, hit_base, start_upd;
    logic [LEN_W-1:0]   tz, lz, run_end;
    logic [CNT_W-1:0]   need, run_upd;
    logic [WORD_W:0]    runs;
    logic               lead_hit, in_hit, small_req, hit, all_clear;

    // range write datapath
    logic [WIDX_W-1:0] lo_w, hi_w;
    logic [BIT_W-1:0]  lo_bit, hi_bit;
    logic [WORD_W-1:0] mask, wr_mod;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.base_page = out_base_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (issue_en)
            rd_data_reg <= mem[issue_addr];
    end

    assign first_x   = XW'(req.first_page);
    assign count_x   = XW'(req.page_count);
    assign total_x   = XW'(TOTAL_PAGES);
    assign rng_bad   = (first_x >= total_x) || (count_x > total_x - first_x);
    assign alloc_bad = (count_x == '0) || (count_x > total_x);

    always_comb
    begin
        wbase     = {pa_reg, BIT_W'(0)};
        tz        = tz_count(rd_data_reg);
        lz        = lz_count(rd_data_reg);
        need      = count_reg - run_reg;
        lead_hit  = need <= CNT_W'(tz);
        lead_base = (run_reg == '0) ? wbase : start_reg;
        small_req = count_reg <= CNT_W'(WORD_W);
        runs      = run_find(~rd_data_reg, count_reg[LEN_W-1:0]);
        in_hit    = small_req && (runs != '0);
        run_end   = lowest_set(runs);
        in_base   = wbase + LPAGE_W'(run_end) - LPAGE_W'(count_reg[LEN_W-1:0]);
        hit       = lead_hit || in_hit;
        hit_base  = lead_hit ? lead_base : in_base;
        all_clear = (tz == LEN_W'(WORD_W));
        run_upd   = all_clear ? run_reg + CNT_W'(WORD_W) : CNT_W'(lz);
        start_upd = all_clear ? lead_base : wbase + LPAGE_W'(WORD_W) - LPAGE_W'(lz);
    end

    always_comb
    begin
        lo_w   = lo_pg_reg[LPAGE_W-1:BIT_W];
        hi_w   = hi_pg_reg[LPAGE_W-1:BIT_W];
        lo_bit = (pa_reg == lo_w) ? lo_pg_reg[BIT_W-1:0] : '0;
        hi_bit = (pa_reg == hi_w) ? hi_pg_reg[BIT_W-1:0] : '1;
        mask   = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));
        wr_mod = set_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_en        = 1'b0;
        issue_addr      = ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = pa_reg;
        wr_data         = wr_mod;
        pv_next         = 1'b0;
        ptr_next        = ptr_reg;
        ptr_end_next    = ptr_end_reg;
        count_next      = count_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        lo_pg_next      = lo_pg_reg;
        hi_pg_next      = hi_pg_reg;
        set_next        = set_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_base_next   = out_base_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = '0;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_WORD)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = ST_DONE;
                    res_base_next   = '0;
                    set_next        = (req.req_type == REQ_MARK);
                    state_next      = S_DONE;
                    case (req.req_type)
                        REQ_ALLOC:
                        begin
                            if (alloc_bad)
                                res_status_next = ST_NOFIT;
                            else
                            begin
                                count_next   = CNT_W'(count_x);
                                run_next     = '0;
                                start_next   = '0;
                                ptr_next     = '0;
                                ptr_end_next = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        REQ_FREE, REQ_MARK:
                        begin
                            if (rng_bad)
                                res_status_next = ST_RANGE;
                            else if (count_x != '0)
                            begin
                                lo_pg_next   = LPAGE_W'(first_x);
                                hi_pg_next   = LPAGE_W'(first_x + count_x - 1'b1);
                                ptr_next     = first_x[LPAGE_W-1:BIT_W];
                                ptr_end_next = 1'b0;
                                state_next   = S_WRITE;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                issue_en = !ptr_end_reg;
                pv_next  = issue_en;
                if (issue_en)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_reg == LAST_WORD)
                        ptr_end_next = 1'b1;
                end
                if (pv_reg)
                begin
                    if (hit)
                    begin
                        // drop the read in flight and set the run
                        lo_pg_next    = hit_base;
                        hi_pg_next    = hit_base + LPAGE_W'(count_reg) - 1'b1;
                        set_next      = 1'b1;
                        res_base_next = hit_base;
                        ptr_next      = hit_base[LPAGE_W-1:BIT_W];
                        ptr_end_next  = 1'b0;
                        pv_next       = 1'b0;
                        state_next    = S_WRITE;
                    end
                    else if (pa_reg == LAST_WORD)
                    begin
                        res_status_next = ST_NOFIT;
                        pv_next         = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        run_next   = run_upd;
                        start_next = start_upd;
                    end
                end
            end

            S_WRITE:
            begin
                issue_en = !ptr_end_reg;
                pv_next  = issue_en;
                if (issue_en)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_reg == hi_w)
                        ptr_end_next = 1'b1;
                end
                if (pv_reg)
                begin
                    wr_en = 1'b1;
                    if (pa_reg == hi_w)
                        state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_base_next   = PAGE_W'(res_base_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pv_reg        <= 1'b0;
            ptr_reg       <= '0;
            ptr_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            ptr_reg       <= ptr_next;
            ptr_end_reg   <= ptr_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_en)
            pa_reg <= issue_addr;
        count_reg      <= count_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        lo_pg_reg      <= lo_pg_next;
        hi_pg_reg      <= hi_pg_next;
        set_reg        <= set_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        out_status_reg <= out_status_next;
        out_base_reg   <= out_base_next;
    end

endmodule

`default_nettype wire

>>> hdl/bpa_check.sv
// Port-level checker for the bitmap page allocator, bound to the top level.
`default_nettype none

`include "bitmap_page_allocator_top_macros.svh"

module bpa_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bpa_pkg::STATUS_W-1:0]  status,
    input logic [bpa_pkg::PAGE_W-1:0]    base_page
);
    import bpa_pkg::*;

    // the bitmap clear keeps requests out right after reset
    `BPA_ASSERT_ALWAYS(a_no_ready_in_reset, !rst_n |=> !req_ready, "ready right after reset")

    // one request at a time
    `BPA_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "request taken back to back")

    `BPA_ASSERT(a_status_code, rsp_valid |-> (status == ST_DONE || status == ST_NOFIT || status == ST_RANGE), "bad status code")

    `BPA_ASSERT(a_base_zero_on_fail, rsp_valid && status != ST_DONE |-> base_page == '0, "base page set on failure")

    `BPA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(base_page), "stalled result changed")

endmodule

bind bitmap_page_allocator_top bpa_check u_bpa_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .base_page (rsp.base_page)
);

`default_nettype wire
